### rtl/core/bdsc_pkg.sv
// ---------------------------------------------------------------------------
// bdsc_pkg: shared definitions for the blinking digit scan controller
// Mode codes, register indexes, reset values and field widths.
// ---------------------------------------------------------------------------
package bdsc_pkg;

    localparam int DIGIT_BITS   = 4;
    localparam int NUM_DIGITS   = 6;
    localparam int SCAN_BITS    = 3;
    localparam int POLL_BITS    = 4;
    localparam int PHASE_BITS   = 8;
    localparam int TIMEOUT_BITS = 4;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 16;

    localparam logic [POLL_BITS-1:0]    POLL_TICKS_RESET     = POLL_BITS'(4);
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_PHASES_RESET = TIMEOUT_BITS'(5);
    localparam logic [PHASE_BITS-1:0]   PHASE_TICKS_RESET    = PHASE_BITS'(200);
    localparam logic [SCAN_BITS-1:0]    PAIR_SKIP            = SCAN_BITS'(2);

    // tens digit of each blinking pair
    localparam logic [SCAN_BITS-1:0] HOURS_PAIR   = SCAN_BITS'(0);
    localparam logic [SCAN_BITS-1:0] MINUTES_PAIR = SCAN_BITS'(2);
    localparam logic [SCAN_BITS-1:0] LAST_DIGIT   = SCAN_BITS'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_HOURS   = 2'd1,
        MODE_MINUTES = 2'd2
    } mode_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_POLL_TICKS     = 2'd0,
        CFG_PHASE_TICKS    = 2'd1,
        CFG_TIMEOUT_PHASES = 2'd2
    } cfg_index_t;

endpackage

### rtl/core/blinking_digit_scan_controller_unit.sv
// ---------------------------------------------------------------------------
// blinking_digit_scan_controller_unit: six-digit display scan with blink mode
// Polls the buttons, runs the set-mode machine and blink timer, and drives
// one active-low digit enable with that digit's symbol per scan tick.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  s_      | in  | buttons and six digit symbols, one scan tick per transaction
//  m_      | out | digit enables, symbol and mode, one per input transaction
//  cfg_    | in  | poll_ticks, phase_ticks, timeout_phases writes
//
//  state is updated at acceptance and the result lands in the output
//  register on the same edge. a new transaction is taken whenever the
//  output register is empty or is being drained, so back-to-back ticks
//  run at full rate.
//  aresetn (synchronous, active low) restores the register and state defaults.
// ---------------------------------------------------------------------------
module blinking_digit_scan_controller_unit
    import bdsc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [0] setting_pressed, [1] up_pressed, [2] down_pressed, [6:3] hours_tens,
    // [10:7] hours_units, [14:11] minutes_tens, [18:15] minutes_units,
    // [22:19] seconds_tens, [26:23] seconds_units, [31:27] zero
    input  logic [IN_DATA_BITS-1:0]  s_tdata,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [5:0] digit_enable_n, [9:6] segment_symbol, [11:10] display_mode,
    // [15:12] zero
    output logic [OUT_DATA_BITS-1:0] m_tdata,

    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic [POLL_BITS-1:0]    poll_ticks_reg;
    logic [PHASE_BITS-1:0]   phase_ticks_reg;
    logic [TIMEOUT_BITS-1:0] timeout_phases_reg;

    mode_t                   mode_reg, mode_next;
    logic [POLL_BITS-1:0]    poll_counter_reg, poll_counter_next;
    logic                    blank_phase_reg, blank_phase_next;
    logic [PHASE_BITS-1:0]   phase_counter_reg, phase_counter_next;
    logic [TIMEOUT_BITS-1:0] phases_left_reg, phases_left_next;
    logic [SCAN_BITS-1:0]    scan_index_reg, scan_index_next;
    logic [SCAN_BITS-1:0]    blink_index;

    logic                    out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg, out_data_next;

    logic                    accept;
    logic                    set_btn, adj_btn;
    logic [DIGIT_BITS-1:0]   digits [NUM_DIGITS];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign set_btn = s_tdata[0];
    assign adj_btn = s_tdata[1] | s_tdata[2];

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digits[i] = s_tdata[3 + i*DIGIT_BITS +: DIGIT_BITS];
        end
    end

    // mode machine, poll sampling and blink timer
    always_comb begin
        logic [POLL_BITS-1:0]  poll_dec;
        logic                  sample;
        logic                  blink_run;
        logic [SCAN_BITS-1:0]  pair_tens;
        logic [PHASE_BITS-1:0] pc_dec;
        mode_next          = mode_reg;
        blank_phase_next   = blank_phase_reg;
        phase_counter_next = phase_counter_reg;
        phases_left_next   = phases_left_reg;
        blink_index        = scan_index_reg;
        blink_run          = 1'b0;
        pair_tens          = HOURS_PAIR;
        pc_dec             = '0;

        poll_dec          = poll_counter_reg - POLL_BITS'(1);
        sample            = (poll_dec == '0);
        poll_counter_next = sample ? poll_ticks_reg : poll_dec;

        case (mode_reg)
            MODE_NORMAL: begin
                if (sample && set_btn) begin
                    mode_next          = MODE_HOURS;
                    blank_phase_next   = 1'b1;
                    phases_left_next   = timeout_phases_reg;
                    phase_counter_next = phase_ticks_reg;
                end
            end
            MODE_HOURS, MODE_MINUTES: begin
                blink_run = 1'b1;
                pair_tens = (mode_reg == MODE_HOURS) ? HOURS_PAIR : MINUTES_PAIR;
                if (sample) begin
                    if (set_btn) begin
                        if (mode_reg == MODE_HOURS) begin
                            mode_next          = MODE_MINUTES;
                            blank_phase_next   = 1'b1;
                            phases_left_next   = timeout_phases_reg;
                            phase_counter_next = phase_ticks_reg;
                        end else begin
                            mode_next = MODE_NORMAL;
                        end
                    end else if (adj_btn) begin
                        // restart with the digits shown
                        blank_phase_next   = 1'b0;
                        phases_left_next   = timeout_phases_reg;
                        phase_counter_next = phase_ticks_reg;
                    end
                end
            end
            default: begin
            end
        endcase

        if (blink_run) begin
            pc_dec = phase_counter_next - PHASE_BITS'(1);
            if (pc_dec == '0) begin
                phases_left_next   = phases_left_next - TIMEOUT_BITS'(1);
                phase_counter_next = phase_ticks_reg;
                if (phases_left_next == '0) begin
                    mode_next = MODE_NORMAL;
                end else if (!blank_phase_next && blink_index == pair_tens) begin
                    blink_index = blink_index + PAIR_SKIP;
                end
                blank_phase_next = !blank_phase_next;
            end else begin
                phase_counter_next = pc_dec;
                if (blank_phase_next && blink_index == pair_tens) begin
                    blink_index = blink_index + PAIR_SKIP;
                end
            end
        end
    end

    // digit scan and result word
    always_comb begin
        logic [NUM_DIGITS-1:0] enable_n;
        logic [DIGIT_BITS-1:0] symbol;
        enable_n        = '1;
        symbol          = '0;
        scan_index_next = '0;
        if (blink_index < SCAN_BITS'(NUM_DIGITS)) begin
            enable_n        = ~(NUM_DIGITS'(1) << blink_index);
            symbol          = digits[blink_index];
            scan_index_next = (blink_index == LAST_DIGIT) ? '0
                                                          : blink_index + SCAN_BITS'(1);
        end
        out_data_next = {4'b0000, mode_next, symbol, enable_n};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_ticks_reg     <= POLL_TICKS_RESET;
            phase_ticks_reg    <= PHASE_TICKS_RESET;
            timeout_phases_reg <= TIMEOUT_PHASES_RESET;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_POLL_TICKS:     poll_ticks_reg     <= cfg_wdata[POLL_BITS-1:0];
                CFG_PHASE_TICKS:    phase_ticks_reg    <= cfg_wdata[PHASE_BITS-1:0];
                CFG_TIMEOUT_PHASES: timeout_phases_reg <= cfg_wdata[TIMEOUT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_NORMAL;
            poll_counter_reg  <= POLL_TICKS_RESET;
            blank_phase_reg   <= 1'b1;
            phase_counter_reg <= PHASE_TICKS_RESET;
            phases_left_reg   <= TIMEOUT_PHASES_RESET;
            scan_index_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg          <= mode_next;
                poll_counter_reg  <= poll_counter_next;
                blank_phase_reg   <= blank_phase_next;
                phase_counter_reg <= phase_counter_next;
                phases_left_reg   <= phases_left_next;
                scan_index_reg    <= scan_index_next;
                out_valid_reg     <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

### tb/scan_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// scan_result_checker: result prediction and comparison for the scan controller
// Tracks configuration writes, predicts the digit enable, symbol and mode of
// every accepted scan tick and compares each drained result in order.
// ---------------------------------------------------------------------------
module scan_result_checker
    import bdsc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,

    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,

    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    output int                       fail_count,
    output int                       pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IN_DATA_BITS-3-NUM_DIGITS*DIGIT_BITS-1:0] zero_pad;
        logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0]            digits;
        logic                                             down_pressed;
        logic                                             up_pressed;
        logic                                             setting_pressed;
    } scan_tick_t;

    typedef struct packed {
        logic [OUT_DATA_BITS-2-DIGIT_BITS-NUM_DIGITS-1:0] zero_pad;
        mode_t                                            display_mode;
        logic [DIGIT_BITS-1:0]                            segment_symbol;
        logic [NUM_DIGITS-1:0]                            digit_enable_n;
    } scan_result_t;

    // settings
    logic [POLL_BITS-1:0]    poll_period;
    logic [PHASE_BITS-1:0]   phase_length;
    logic [TIMEOUT_BITS-1:0] timeout_length;

    // controller state
    mode_t                   mode_q;
    logic [POLL_BITS-1:0]    poll_left;
    logic                    blanked;
    logic [PHASE_BITS-1:0]   phase_left;
    logic [TIMEOUT_BITS-1:0] phases_left;
    logic [SCAN_BITS-1:0]    scan_pos;

    scan_result_t expected_scans[$];
    int           failures = 0;
    int           results_seen = 0;

    function automatic void restart_blink_timer();
        blanked     = 1'b1;
        phases_left = timeout_length;
        phase_left  = phase_length;
    endfunction

    function automatic void advance_blink(input logic [SCAN_BITS-1:0] pair_tens);
        phase_left = phase_left - 1'b1;
        if (phase_left == '0) begin
            phases_left = phases_left - 1'b1;
            if (phases_left == '0) begin
                mode_q = MODE_NORMAL;
            end else if (!blanked && scan_pos == pair_tens) begin
                // end of a shown phase skips the pair once
                scan_pos = scan_pos + PAIR_SKIP;
            end
            phase_left = phase_length;
            blanked    = !blanked;
        end else if (blanked && scan_pos == pair_tens) begin
            scan_pos = scan_pos + PAIR_SKIP;
        end
    endfunction

    function automatic scan_result_t predict_scan(input scan_tick_t tick);
        scan_result_t result;
        mode_t        start_mode;
        logic         sample;
        logic         adjust;
        result                = '0;
        result.digit_enable_n = '1;
        adjust                = tick.up_pressed | tick.down_pressed;
        start_mode            = mode_q;

        poll_left = poll_left - 1'b1;
        sample    = (poll_left == '0);
        if (sample) begin
            poll_left = poll_period;
        end

        case (start_mode)
            MODE_NORMAL: begin
                if (sample && tick.setting_pressed) begin
                    mode_q = MODE_HOURS;
                    restart_blink_timer();
                end
            end
            MODE_HOURS, MODE_MINUTES: begin
                if (sample && tick.setting_pressed) begin
                    if (start_mode == MODE_HOURS) begin
                        mode_q = MODE_MINUTES;
                        restart_blink_timer();
                    end else begin
                        mode_q = MODE_NORMAL;
                    end
                end else if (sample && adjust) begin
                    // adjusting restarts the timer with the pair shown
                    restart_blink_timer();
                    blanked = 1'b0;
                end
                // timer runs on the mode held at the start of the tick
                advance_blink((start_mode == MODE_HOURS) ? HOURS_PAIR : MINUTES_PAIR);
            end
            default: begin
            end
        endcase

        if (scan_pos < NUM_DIGITS) begin
            result.digit_enable_n[scan_pos] = 1'b0;
            result.segment_symbol           = tick.digits[scan_pos];
            scan_pos = (scan_pos == LAST_DIGIT) ? '0 : scan_pos + 1'b1;
        end else begin
            scan_pos = '0;
        end
        result.display_mode = mode_q;
        return result;
    endfunction

    always @(posedge aclk) begin : monitor
        scan_result_t got;
        scan_result_t want;
        if (!aresetn) begin
            poll_period    = POLL_TICKS_RESET;
            phase_length   = PHASE_TICKS_RESET;
            timeout_length = TIMEOUT_PHASES_RESET;
            mode_q         = MODE_NORMAL;
            poll_left      = POLL_TICKS_RESET;
            blanked        = 1'b1;
            phase_left     = PHASE_TICKS_RESET;
            phases_left    = TIMEOUT_PHASES_RESET;
            scan_pos       = '0;
            expected_scans.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_POLL_TICKS:     poll_period    = cfg_wdata[POLL_BITS-1:0];
                    CFG_PHASE_TICKS:    phase_length   = cfg_wdata[PHASE_BITS-1:0];
                    CFG_TIMEOUT_PHASES: timeout_length = cfg_wdata[TIMEOUT_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // drain first: a result never leaves on the edge its tick enters
            if (m_tvalid && m_tready) begin
                got = scan_result_t'(m_tdata);
                if (expected_scans.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("result %0d arrived with no tick pending: %h",
                                 results_seen, m_tdata);
                    end
                end else begin
                    want = expected_scans.pop_front();
                    if (got.digit_enable_n !== want.digit_enable_n ||
                        got.segment_symbol !== want.segment_symbol ||
                        got.display_mode !== want.display_mode ||
                        got.zero_pad !== want.zero_pad) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("result %0d mismatch: enables %b/%b symbol %h/%h",
                                     results_seen, want.digit_enable_n,
                                     got.digit_enable_n, want.segment_symbol,
                                     got.segment_symbol);
                            $display("    mode %0d/%0d padding %h/%h (expected/actual)",
                                     want.display_mode, got.display_mode,
                                     want.zero_pad, got.zero_pad);
                        end
                    end
                end
                results_seen++;
            end

            if (s_tvalid && s_tready) begin
                expected_scans.push_back(predict_scan(scan_tick_t'(s_tdata)));
            end
        end
        pending    <= expected_scans.size();
        fail_count <= failures;
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: scan controller regression
// Drives scan ticks with held button presses through several blink and poll
// settings, under random stalls on both channels; the checker does the rest.
// ---------------------------------------------------------------------------
module testbench
    import bdsc_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES = 6;
    localparam int DIRECTED_ITEMS = 26;

    // button codes, bit 0 setting, bit 1 up, bit 2 down
    localparam logic [2:0] BTN_NONE = 3'b000;
    localparam logic [2:0] BTN_SET  = 3'b001;
    localparam logic [2:0] BTN_UP   = 3'b010;
    localparam logic [2:0] BTN_DOWN = 3'b100;

    // first poll comes on the fourth tick after reset
    localparam logic [2:0] DIRECTED_BUTTONS [DIRECTED_ITEMS] = '{
        BTN_NONE, BTN_NONE, BTN_NONE, BTN_SET, BTN_NONE, BTN_NONE, BTN_NONE,
        BTN_NONE, BTN_UP, BTN_NONE, BTN_DOWN, BTN_NONE, BTN_NONE, BTN_SET,
        BTN_NONE, BTN_NONE, BTN_NONE, BTN_UP | BTN_DOWN, BTN_SET, BTN_SET,
        BTN_NONE, BTN_NONE, BTN_NONE, BTN_NONE, BTN_NONE, BTN_NONE
    };

    // per phase settings; phase 0 runs the directed ticks
    localparam logic [POLL_BITS-1:0]    POLL_SET    [PHASES] =
        '{4'd1, 4'd2, 4'd15, 4'd1, 4'd0, 4'd3};
    localparam logic [PHASE_BITS-1:0]   PHASE_SET   [PHASES] =
        '{8'd3, 8'd5, 8'd1, 8'd255, 8'd0, 8'd4};
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_SET [PHASES] =
        '{4'd2, 4'd3, 4'd15, 4'd1, 4'd0, 4'd4};
    localparam int RANDOM_ITEMS [PHASES] = '{0, 130, 130, 100, 60, 130};
    localparam int SEND_IDLE    [PHASES] = '{38, 38, 52, 52, 0, 0};
    localparam int RECV_IDLE    [PHASES] = '{52, 52, 38, 38, 0, 0};

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // held button levels for the random ticks
    logic set_level = 1'b0;
    logic up_level = 1'b0;
    logic down_level = 1'b0;

    blinking_digit_scan_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    scan_result_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [IN_DATA_BITS-1:0] pack_tick(
        input logic [2:0] buttons,
        input logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits
    );
        return IN_DATA_BITS'({digits, buttons});
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] random_tick();
        logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits;
        foreach (digits[i]) begin
            digits[i] = DIGIT_BITS'($urandom);
        end
        // occasional noise on the buttons, otherwise presses held a few ticks
        if ($urandom_range(99) < 8) begin
            return pack_tick(3'($urandom), digits);
        end
        set_level  = set_level  ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 3);
        up_level   = up_level   ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 2);
        down_level = down_level ? ($urandom_range(99) >= 40) : ($urandom_range(99) < 2);
        return pack_tick({down_level, up_level, set_level}, digits);
    endfunction

    task automatic send_tick(input logic [IN_DATA_BITS-1:0] tick);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tick;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending != 0);
    endtask

    task automatic load_settings(
        input logic [POLL_BITS-1:0]    poll,
        input logic [PHASE_BITS-1:0]   phase,
        input logic [TIMEOUT_BITS-1:0] timeout
    );
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_POLL_TICKS;
        cfg_wdata <= CFG_DATA_BITS'(poll);
        @(posedge aclk);
        cfg_addr  <= CFG_PHASE_TICKS;
        cfg_wdata <= CFG_DATA_BITS'(phase);
        @(posedge aclk);
        cfg_addr  <= CFG_TIMEOUT_PHASES;
        cfg_wdata <= CFG_DATA_BITS'(timeout);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [NUM_DIGITS-1:0][DIGIT_BITS-1:0] digits;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_POLL_TICKS;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_results_drained();
            end
            send_idle_pct = SEND_IDLE[p];
            recv_idle_pct = RECV_IDLE[p];
            load_settings(POLL_SET[p], PHASE_SET[p], TIMEOUT_SET[p]);
            if (p == 0) begin
                // enter hours, adjust, move to minutes, leave, re-enter, time out
                for (int i = 0; i < DIRECTED_ITEMS; i++) begin
                    foreach (digits[d]) begin
                        digits[d] = (i == 0) ? '0 : (i == 1) ? '1 : DIGIT_BITS'($urandom);
                    end
                    send_tick(pack_tick(DIRECTED_BUTTONS[i], digits));
                end
            end
            for (int i = 0; i < RANDOM_ITEMS[p]; i++) begin
                send_tick(random_tick());
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bdsc_pkg.sv
rtl/core/blinking_digit_scan_controller_unit.sv
tb/scan_result_checker.sv
tb/testbench.sv
